>>> rtl/hhd_pkg.sv
package hhd_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [16:0] AclLimitReset = 17'd1024;

  localparam logic [7:0] TypeAcl = 8'h02;
  localparam logic [7:0] TypeSco = 8'h03;
  localparam logic [7:0] TypeEvt = 8'h04;

  typedef enum logic [1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_ACL_LIMIT = 2'd1
  } cfg_index_e;

  typedef enum logic [1:0] {
    KIND_ACL = 2'd0,
    KIND_SCO = 2'd1,
    KIND_EVT = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]      kind;
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            is_header;
    logic            ends_packet;
  } entry_t;

endpackage

>>> rtl/hhd_front.sv
module hhd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               enable_i,
  input  logic [16:0]        acl_limit_i,
  input  logic               full_i,
  output logic               push_o,
  output hhd_pkg::entry_t    entry_o
);
  import hhd_pkg::*;

  typedef enum logic [1:0] {
    PH_TYPE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  kind_q, kind_d;
  logic [2:0]  count_q, count_d;
  logic [15:0] left_q, left_d;
  logic [3:0][7:0] store_q;
  logic [3:0][7:0] merged;
  logic [2:0]  hlen;
  logic [15:0] len;
  logic        accept;
  logic        hdr_done;
  logic        oversize;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i && enable_i;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      merged[i] = (count_q[1:0] == 2'(i)) ? rx_byte_i : store_q[i];
    end
    case (kind_q)
      KIND_ACL: hlen = 3'd4;
      KIND_SCO: hlen = 3'd3;
      default:  hlen = 3'd2;
    endcase
    case (kind_q)
      KIND_ACL: len = {merged[3], merged[2]};
      KIND_SCO: len = {8'd0, merged[2]};
      default:  len = {8'd0, merged[1]};
    endcase
    hdr_done = (count_q + 3'd1) == hlen;
    oversize = (kind_q == KIND_ACL) && (({1'b0, len} + 17'd4) > acl_limit_i);
  end

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    count_d = count_q;
    left_d  = left_q;
    push_o  = 1'b0;
    entry_o = '0;
    entry_o.kind = kind_q;
    if (accept) begin
      case (phase_q)
        PH_HEADER: begin
          if (!hdr_done) begin
            count_d = count_q + 3'd1;
          end else if (oversize) begin
            phase_d = PH_TYPE;
            count_d = 3'd0;
          end else begin
            push_o              = 1'b1;
            entry_o.bytes       = merged;
            entry_o.last_idx    = 2'(hlen - 3'd1);
            entry_o.is_header   = 1'b1;
            entry_o.ends_packet = (len == 16'd0);
            count_d             = 3'd0;
            left_d              = len;
            phase_d             = (len == 16'd0) ? PH_TYPE : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          push_o              = 1'b1;
          entry_o.bytes[0]    = rx_byte_i;
          entry_o.last_idx    = 2'd0;
          entry_o.is_header   = 1'b0;
          entry_o.ends_packet = (left_q <= 16'd1);
          left_d              = left_q - 16'd1;
          if (left_d == 16'd0) begin
            phase_d = PH_TYPE;
          end
        end
        default: begin
          if (rx_byte_i inside {TypeAcl, TypeSco, TypeEvt}) begin
            kind_d  = 2'(rx_byte_i - TypeAcl);
            count_d = 3'd0;
            phase_d = PH_HEADER;
          end else begin
            phase_d = PH_TYPE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      kind_q  <= 2'd0;
      count_q <= 3'd0;
      left_q  <= 16'd0;
    end else begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      count_q <= count_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && phase_q == PH_HEADER) begin
      store_q[count_q[1:0]] <= rx_byte_i;
    end
  end

endmodule

>>> rtl/hhd_queue.sv
module hhd_queue #(
  parameter int unsigned Depth = hhd_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hhd_pkg::entry_t entry_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output hhd_pkg::entry_t entry_o
);
  import hhd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count out of range");

endmodule

>>> rtl/hhd_back.sv
module hhd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  hhd_pkg::entry_t entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      packet_kind_o,
  output logic [7:0]      packet_byte_o,
  output logic            first_byte_o,
  output logic            last_byte_o
);
  import hhd_pkg::*;

  logic [1:0] beat_q;
  logic       valid_q;
  logic [1:0] kind_q;
  logic [7:0] byte_q;
  logic       first_q, last_q;
  logic       load;
  logic       final_beat;

  assign load       = valid_i && (!valid_q || out_ready_i);
  assign final_beat = (beat_q == entry_i.last_idx);
  assign pop_o      = load && final_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q  <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        beat_q  <= final_beat ? 2'd0 : beat_q + 2'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= entry_i.kind;
      byte_q  <= entry_i.bytes[beat_q];
      first_q <= entry_i.is_header && (beat_q == 2'd0);
      last_q  <= entry_i.ends_packet && final_beat;
    end
  end

  assign out_valid_o   = valid_q;
  assign packet_kind_o = kind_q;
  assign packet_byte_o = byte_q;
  assign first_byte_o  = first_q;
  assign last_byte_o   = last_q;

  a_mid_entry_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_q != 2'd0 |-> valid_i) else $error("entry left queue mid-flush");
  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !(first_q && last_q)) else $error("one-beat packet emitted");
  a_beat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> beat_q <= entry_i.last_idx) else $error("beat index past entry");

endmodule

>>> rtl/hci_h4_uart_deframer_unit.sv
// Path: a byte that ends a header within limits or carries payload goes to the queue,
//   then the output register; a header flush gives one beat per cycle while
//   out_ready_i is high. Throughput: one byte per cycle is accepted while the
//   front queue has room; a header flush holds the back end for its 2 to 4 bytes.
// Reset: deframer waits for a type byte, enable is 0, ACL limit is 1024,
//   queue and output are empty; the header store is not cleared.
module hci_h4_uart_deframer_unit #(
  parameter int unsigned QueueDepth = hhd_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  packet_kind_o,
  output logic [7:0]  packet_byte_o,
  output logic        first_byte_o,
  output logic        last_byte_o
);
  import hhd_pkg::*;

  logic        enable_q;
  logic [16:0] acl_limit_q;
  logic        push, pop, full, q_valid;
  entry_t      push_entry, head_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      acl_limit_q <= AclLimitReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ENABLE:    enable_q    <= cfg_data_i[0];
        CFG_ACL_LIMIT: acl_limit_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  hhd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .enable_i    (enable_q),
    .acl_limit_i (acl_limit_q),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  hhd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .entry_o (head_entry)
  );

  hhd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packet_kind_o (packet_kind_o),
    .packet_byte_o (packet_byte_o),
    .first_byte_o  (first_byte_o),
    .last_byte_o   (last_byte_o)
  );

endmodule

>>> tb/hci_h4_uart_deframer_unit_tb.sv
module hci_h4_uart_deframer_unit_tb;
  import hhd_pkg::*;

  class h4_scoreboard;
    typedef enum logic [1:0] {AWAIT_TYPE, IN_HEADER, IN_PAYLOAD} stage_e;
    typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       first;
      logic       last;
    } beat_t;

    beat_t       pending_beats[$];
    logic        enable;
    logic [16:0] acl_limit;
    stage_e      stage;
    kind_e       kind_held;
    int unsigned hdr_count;
    logic [7:0]  hdr_bytes[4];
    logic [15:0] payload_left;
    int          errors;

    function new();
      enable       = 1'b0;
      acl_limit    = AclLimitReset;
      stage        = AWAIT_TYPE;
      kind_held    = KIND_ACL;
      hdr_count    = 0;
      payload_left = '0;
      errors       = 0;
    endfunction

    function void set_reg(cfg_index_e idx, logic [16:0] value);
      if (idx == CFG_ENABLE) begin
        enable = value[0];
      end else if (idx == CFG_ACL_LIMIT) begin
        acl_limit = value;
      end
    endfunction

    function bit awaiting_type();
      return stage == AWAIT_TYPE;
    endfunction

    function bit in_payload();
      return stage == IN_PAYLOAD;
    endfunction

    function void deframe_byte(logic [7:0] b);
      int unsigned hlen;
      int unsigned len;
      if (!enable) return;
      case (stage)
        IN_HEADER: begin
          hlen = (kind_held == KIND_ACL) ? 4 : (kind_held == KIND_SCO) ? 3 : 2;
          hdr_bytes[hdr_count] = b;
          hdr_count++;
          if (hdr_count < hlen) return;
          hdr_count = 0;
          case (kind_held)
            KIND_ACL: len = {hdr_bytes[3], hdr_bytes[2]};
            KIND_SCO: len = hdr_bytes[2];
            default:  len = hdr_bytes[1];
          endcase
          // drop oversized ACL without a beat
          if (kind_held == KIND_ACL && 4 + len > acl_limit) begin
            stage = AWAIT_TYPE;
            return;
          end
          for (int i = 0; i < hlen; i++) begin
            pending_beats.push_back(beat_t'{kind_held, hdr_bytes[i], i == 0,
                                            (i == hlen - 1) && (len == 0)});
          end
          payload_left = len[15:0];
          stage = (len == 0) ? AWAIT_TYPE : IN_PAYLOAD;
        end
        IN_PAYLOAD: begin
          pending_beats.push_back(beat_t'{kind_held, b, 1'b0, payload_left <= 1});
          payload_left--;
          if (payload_left == 0) stage = AWAIT_TYPE;
        end
        default: begin
          if (b == TypeAcl || b == TypeSco || b == TypeEvt) begin
            kind_held = kind_e'(2'(b - TypeAcl));
            hdr_count = 0;
            stage     = IN_HEADER;
          end else begin
            stage = AWAIT_TYPE;
          end
        end
      endcase
    endfunction

    task check_beat(logic [1:0] kind, logic [7:0] data, logic first, logic last);
      beat_t want;
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0d byte %02h", kind, data));
        return;
      end
      want = pending_beats.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("packet_kind %0d, want %0d", kind, want.kind));
      if (data !== want.data)
        report_mismatch($sformatf("packet_byte %02h, want %02h", data, want.data));
      if (first !== want.first)
        report_mismatch($sformatf("first_byte %0b, want %0b", first, want.first));
      if (last !== want.last)
        report_mismatch($sformatf("last_byte %0b, want %0b", last, want.last));
    endtask

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_index_e  cfg_index;
  logic [16:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  packet_kind;
  logic [7:0]  packet_byte;
  logic        first_byte;
  logic        last_byte;

  h4_scoreboard sb = new();
  bit src_idle  = 1'b1;
  bit sink_idle = 1'b1;
  bit choke_req = 1'b0;
  int unsigned items_sent = 0;

  hci_h4_uart_deframer_unit u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .packet_kind_o (packet_kind),
    .packet_byte_o (packet_byte),
    .first_byte_o  (first_byte),
    .last_byte_o   (last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : beat_sink
    int unsigned hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_beat(packet_kind, packet_byte, first_byte, last_byte);
        hold = sink_idle ? $urandom_range(0, 13) : 0;
      end
      // hold off long enough to back up the input
      if (choke_req) begin
        choke_req = 1'b0;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_index_e idx, logic [16:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.deframe_byte(b);
    items_sent++;
  endtask

  task automatic send_bytes(logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic send_frame(kind_e kind, int unsigned len, int unsigned body);
    logic [7:0] hdr[4];
    int unsigned hlen;
    hlen = (kind == KIND_ACL) ? 4 : (kind == KIND_SCO) ? 3 : 2;
    for (int i = 0; i < 4; i++) hdr[i] = 8'($urandom_range(0, 255));
    case (kind)
      KIND_ACL: begin
        hdr[2] = len[7:0];
        hdr[3] = len[15:8];
      end
      KIND_SCO: hdr[2] = len[7:0];
      default:  hdr[1] = len[7:0];
    endcase
    send_byte(TypeAcl + 8'(kind));
    for (int i = 0; i < hlen; i++) send_byte(hdr[i]);
    repeat (body) send_byte(8'($urandom_range(0, 255)));
  endtask

  // finish any open header or payload so the next packet starts clean
  task automatic settle_deframer();
    while (!sb.awaiting_type())
      send_byte(sb.in_payload() ? 8'($urandom_range(0, 255)) : 8'h00);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [16:0] limit;
    int unsigned len;
    int unsigned phase_end;
    int unsigned r;
    bit          saved_idle;
    kind_e       kind;

    cfg_valid <= 1'b0;
    cfg_index <= CFG_ENABLE;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    rx_byte   <= '0;
    rst_n     <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ignored while closed
    send_bytes('{TypeAcl});
    wait_drained();
    write_reg(CFG_ENABLE, 17'd1);

    send_bytes('{TypeEvt, 8'h0E, 8'h00,
                 TypeAcl, 8'hFF, 8'h0F, 8'h02, 8'h00, 8'hAA, 8'h55,
                 TypeSco, 8'h00, 8'hFF, 8'h01, 8'h80,
                 8'h00, 8'hFF, 8'h05, 8'h01,
                 TypeAcl, 8'h01, 8'h00, 8'hFF, 8'hFF,
                 TypeEvt, 8'h3E, 8'h02, 8'h11});
    wait_drained();
    write_reg(CFG_ENABLE, 17'd0);
    send_bytes('{TypeEvt});
    wait_drained();
    write_reg(CFG_ENABLE, 17'd1);
    send_bytes('{8'h22});
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       limit = AclLimitReset;
        1:       limit = 17'd4;
        2:       limit = 17'd65539;
        3:       limit = 17'($urandom_range(4, 40));
        4:       limit = 17'd3;
        default: limit = 17'($urandom_range(4, 65539));
      endcase
      write_reg(CFG_ACL_LIMIT, limit);
      src_idle  = (p != 2) && ($urandom_range(0, 3) != 0);
      sink_idle = (p != 2) && ($urandom_range(0, 3) != 0);

      if (p == 1) begin
        settle_deframer();
        send_frame(KIND_EVT, 4, 4);
        wait_drained();
      end
      if (p == 3) begin
        settle_deframer();
        saved_idle = src_idle;
        src_idle   = 1'b0;
        choke_req  = 1'b1;
        send_frame(KIND_EVT, 20, 20);
        src_idle   = saved_idle;
      end

      phase_end = items_sent + 6;
      while (items_sent < phase_end) begin
        settle_deframer();
        r    = $urandom_range(0, 9);
        kind = kind_e'($urandom_range(0, 2));
        if (r < 7) begin
          if ($urandom_range(0, 15) == 0)
            len = $urandom_range(0, 24);
          else
            len = $urandom_range(0, 6);
          send_frame(kind, len, (kind == KIND_ACL && 4 + len > limit) ? 0 : len);
        end else if (r == 7) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end else if (r == 8) begin
          send_byte(TypeAcl + 8'(kind));
          repeat ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)));
        end else if (limit >= 4 && limit < 65539) begin
          send_frame(KIND_ACL, $urandom_range(limit - 3, 65535), 0);
        end else begin
          send_frame(kind, 3, $urandom_range(0, 2));
        end
      end
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/hhd_pkg.sv
rtl/hhd_front.sv
rtl/hhd_queue.sv
rtl/hhd_back.sv
rtl/hci_h4_uart_deframer_unit.sv
tb/hci_h4_uart_deframer_unit_tb.sv
